FILE: hw/rtl/opp_pkg.sv
package opp_pkg;

  // Sizing
  localparam int OPP_STACK_DEPTH = 32;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_W           = $clog2(MAX_RESULTS);
  localparam int TOK_W           = 5;
  localparam int KIND_W          = 3;
  localparam int RULE_W          = 5;
  localparam int SYM_W           = 5;
  localparam int NUM_TERM        = 18;

  // Stack symbol codes
  localparam logic [SYM_W-1:0] SYM_LAST_OP = 5'd10;
  localparam logic [SYM_W-1:0] SYM_LPAR    = 5'd11;
  localparam logic [SYM_W-1:0] SYM_RPAR    = 5'd12;
  localparam logic [SYM_W-1:0] SYM_OPND_LO = 5'd13;
  localparam logic [SYM_W-1:0] SYM_OPND_HI = 5'd16;
  localparam logic [SYM_W-1:0] SYM_END     = 5'd17;
  localparam logic [SYM_W-1:0] SYM_MARK    = 5'd18;
  localparam logic [SYM_W-1:0] SYM_NT      = 5'd19;

  localparam logic [RULE_W-1:0] RULE_NONE  = 5'd0;
  localparam logic [RULE_W-1:0] RULE_PAREN = 5'd12;

  typedef enum logic [KIND_W-1:0] {
    KIND_REDUCE   = 3'd0,
    KIND_SHIFT    = 3'd1,
    KIND_ACCEPT   = 3'd2,
    KIND_SYNTAX   = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REL_LT  = 3'd0,
    REL_EQ  = 3'd1,
    REL_GT  = 3'd2,
    REL_ERR = 3'd3,
    REL_ACC = 3'd4
  } rel_t;

  // One stack entry: symbol plus the topmost terminal at or below it
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] tt;
  } ent_t;

  localparam ent_t BOTTOM_ENT = '{sym: SYM_END, tt: SYM_END};

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_DN1  = 3'd1,
    OP_DN2  = 3'd2,
    OP_UP1  = 3'd3,
    OP_UP3  = 3'd4,
    OP_CLR  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load_en;
    ent_t     load_ent;
  } cell_ctl_t;

  // Precedence rows, first character is column 0
  localparam logic [8*NUM_TERM-1:0] ROW_A = ">>>>>>>>>>><><<<<>";
  localparam logic [8*NUM_TERM-1:0] ROW_B = "<>><<>>>>>><><<<<>";
  localparam logic [8*NUM_TERM-1:0] ROW_C = "<>><>>>>>>><><<<<>";
  localparam logic [8*NUM_TERM-1:0] ROW_D = "<<<<<>>>>>><><<<<>";
  localparam logic [8*NUM_TERM-1:0] ROW_E = "<<<<<<<<<<<<=<<<<E";
  localparam logic [8*NUM_TERM-1:0] ROW_F = ">>>>>>>>>>>E>EEEE>";
  localparam logic [8*NUM_TERM-1:0] ROW_G = "<<<<<<<<<<<<E<<<<$";

  function automatic rel_t prec_rel(input logic [SYM_W-1:0] row,
                                    input logic [SYM_W-1:0] col);
    logic [8*NUM_TERM-1:0] line;
    logic [7:0]            ch;
    rel_t                  rel;
    case (row) inside
      5'd0, 5'd3:  line = ROW_A;
      [5'd1:5'd2]: line = ROW_B;
      5'd4:        line = ROW_C;
      [5'd5:5'd10]: line = ROW_D;
      5'd11:       line = ROW_E;
      [5'd12:5'd16]: line = ROW_F;
      default:     line = ROW_G;
    endcase
    if (row > SYM_END || col > SYM_END) begin
      ch = "E";
    end else begin
      ch = line[8*(NUM_TERM-1-int'(col)) +: 8];
    end
    case (ch)
      "<":     rel = REL_LT;
      "=":     rel = REL_EQ;
      ">":     rel = REL_GT;
      "$":     rel = REL_ACC;
      default: rel = REL_ERR;
    endcase
    return rel;
  endfunction

endpackage

FILE: hw/rtl/opp_if.sv
// Token request channel
interface opp_in_if import opp_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [TOK_W-1:0] token_class;

  modport source (output valid, output token_class, input ready);
  modport sink (input valid, input token_class, output ready);
endinterface

// Result request channel
interface opp_out_if import opp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [RULE_W-1:0] rule;
  logic              last;

  modport source (output valid, output kind, output rule, output last, input ready);
  modport sink (input valid, input kind, input rule, input last, output ready);
endinterface

FILE: hw/rtl/opp_cell.sv
// One stack slot; slot 0 is the top of stack
module opp_cell import opp_pkg::*; #(
  parameter ent_t CLR_ENT = '0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  ent_t      dn1,   // slot one above
  input  ent_t      dn2,   // slot two above
  input  ent_t      up1,   // slot one below
  input  ent_t      up3,   // slot three below
  output ent_t      ent
);

  ent_t ent_r;
  ent_t ent_nxt;

  // push moves entries away from the top, pop toward it
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load_en) begin
      ent_nxt = ctl.load_ent;
    end else begin
      case (ctl.op)
        OP_HOLD: ent_nxt = ent_r;
        OP_DN1:  ent_nxt = dn1;
        OP_DN2:  ent_nxt = dn2;
        OP_UP1:  ent_nxt = up1;
        OP_UP3:  ent_nxt = up3;
        OP_CLR:  ent_nxt = CLR_ENT;
        default: ent_nxt = ent_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= CLR_ENT;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

FILE: hw/rtl/operator_precedence_parser_core.sv
// Operator-precedence expression parser.
// in_chan takes one token class per request (valid/ready). out_chan gives
// one request per result: a reduction with its rule number, or a final
// shift, accept, syntax error or overflow flagged with last.
// A token is taken only while the parser is idle. After it is taken the
// evaluate state loads each result into the output register, reductions
// first and the final result last, the turn-around being one symbol-stack
// update per cycle in the chain of slots while the output register is free.
// A new token may be taken while the final result still waits.
// When out_chan stalls, work holds until the output register is free.
// The stack is a row of STACK_DEPTH slots that shift one or two places on
// a push and one or three on a reduction; each slot carries the nearest
// terminal at or below it, so the top slot gives the precedence row directly.
// Reset (rst_n low, synchronous) leaves the end marker alone on the stack,
// the output empty and the parser idle; accept and every error return the
// stack to that state in the same cycle.
module operator_precedence_parser_core import opp_pkg::*; #(
  parameter int STACK_DEPTH = OPP_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  opp_in_if.sink    in_chan,
  opp_out_if.source out_chan
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [TOK_W-1:0]  tok_r, tok_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RES_W-1:0]  nres_r, nres_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic [RULE_W-1:0] rule_r, rule_nxt;
  logic              last_r, last_nxt;

  ent_t              ent_w [STACK_DEPTH];
  cell_op_t          cell_op;
  logic [2:0]        ld_en;
  ent_t              ld_ent [3];

  ent_t              c0, c1, c2, c3;
  rel_t              rel;
  logic              tok_bad;
  logic              c0_stop, c1_stop, c2_stop;
  logic              len2, len4;
  logic [RULE_W-1:0] rule2, rule4, hrule;
  logic [1:0]        need;
  logic              ovf;
  logic              go;

  assign c0 = ent_w[0];
  assign c1 = ent_w[1];
  assign c2 = ent_w[2];
  assign c3 = ent_w[3];

  // Relation between top terminal and the token
  assign tok_bad = tok_r > SYM_END;
  assign rel     = prec_rel(c0.tt, tok_r);

  // Handle shape: marker found one or three slots below the top
  assign c0_stop = (c0.sym == SYM_MARK) || (c0.sym == SYM_END);
  assign c1_stop = (c1.sym == SYM_MARK) || (c1.sym == SYM_END);
  assign c2_stop = (c2.sym == SYM_MARK) || (c2.sym == SYM_END);
  assign len2    = !c0_stop && (c1.sym == SYM_MARK);
  assign len4    = !c0_stop && !c1_stop && !c2_stop && (c3.sym == SYM_MARK);

  always_comb begin
    rule2 = RULE_NONE;
    if (c0.sym inside {[SYM_OPND_LO:SYM_OPND_HI]}) begin
      rule2 = c0.sym;
    end
    rule4 = RULE_NONE;
    if (c2.sym == SYM_NT && c0.sym == SYM_NT && c1.sym <= SYM_LAST_OP) begin
      rule4 = c1.sym + 5'd1;
    end else if (c2.sym == SYM_LPAR && c1.sym == SYM_NT && c0.sym == SYM_RPAR) begin
      rule4 = RULE_PAREN;
    end
    if (len2) begin
      hrule = rule2;
    end else if (len4) begin
      hrule = rule4;
    end else begin
      hrule = RULE_NONE;
    end
  end

  // Room check for a push of one or two slots
  assign need = (rel == REL_LT) ? 2'd2 : 2'd1;
  assign ovf  = ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(need)) > (CNT_W+1)'(STACK_DEPTH);

  assign go = !out_valid_r || out_chan.ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    cnt_nxt       = cnt_r;
    nres_nxt      = nres_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    kind_nxt      = kind_r;
    rule_nxt      = rule_r;
    last_nxt      = last_r;
    cell_op       = OP_HOLD;
    ld_en         = 3'b000;
    ld_ent[0]     = '0;
    ld_ent[1]     = '0;
    ld_ent[2]     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          tok_nxt   = in_chan.token_class;
          nres_nxt  = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          rule_nxt      = RULE_NONE;
          last_nxt      = 1'b1;
          kind_nxt      = KIND_SYNTAX;
          cell_op       = OP_CLR;
          cnt_nxt       = CNT_W'(1);
          if (!tok_bad) begin
            case (rel)
              REL_ACC: begin
                kind_nxt = KIND_ACCEPT;
              end
              REL_LT, REL_EQ: begin
                if (ovf) begin
                  kind_nxt = KIND_OVERFLOW;
                end else begin
                  kind_nxt  = KIND_SHIFT;
                  ld_en[0]  = 1'b1;
                  ld_ent[0] = '{sym: tok_r, tt: tok_r};
                  if (rel == REL_EQ) begin
                    cell_op = OP_DN1;
                    cnt_nxt = cnt_r + CNT_W'(1);
                  end else begin
                    cell_op  = OP_DN2;
                    cnt_nxt  = cnt_r + CNT_W'(2);
                    ld_en[1] = 1'b1;
                    if (c0.sym == SYM_NT) begin
                      // marker goes below the nonterminal on top
                      ld_ent[1] = '{sym: SYM_NT, tt: c0.tt};
                      ld_en[2]  = 1'b1;
                      ld_ent[2] = '{sym: SYM_MARK, tt: c0.tt};
                    end else begin
                      ld_ent[1] = '{sym: SYM_MARK, tt: c0.tt};
                    end
                  end
                end
              end
              REL_GT: begin
                if (hrule == RULE_NONE) begin
                  kind_nxt = KIND_SYNTAX;
                end else if (nres_r >= RES_W'(MAX_RESULTS - 1)) begin
                  kind_nxt = KIND_OVERFLOW;
                end else begin
                  // pop the handle, nonterminal takes the marker's slot
                  kind_nxt  = KIND_REDUCE;
                  rule_nxt  = hrule;
                  last_nxt  = 1'b0;
                  nres_nxt  = nres_r + RES_W'(1);
                  ld_en[0]  = 1'b1;
                  if (len4) begin
                    cell_op   = OP_UP3;
                    cnt_nxt   = cnt_r - CNT_W'(3);
                    ld_ent[0] = '{sym: SYM_NT, tt: c3.tt};
                  end else begin
                    cell_op   = OP_UP1;
                    cnt_nxt   = cnt_r - CNT_W'(1);
                    ld_ent[0] = '{sym: SYM_NT, tt: c1.tt};
                  end
                end
              end
              default: begin
                kind_nxt = KIND_SYNTAX;
              end
            endcase
          end
          if (last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(1);
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nres_r      <= nres_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    kind_r <= kind_nxt;
    rule_r <= rule_nxt;
    last_r <= last_nxt;
  end

  // Stack slots
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    ent_t      dn1, dn2, up1, up3;
    cell_ctl_t ctl;

    if (i >= 1) begin : g_dn1
      assign dn1 = ent_w[i-1];
    end else begin : g_dn1_z
      assign dn1 = '0;
    end
    if (i >= 2) begin : g_dn2
      assign dn2 = ent_w[i-2];
    end else begin : g_dn2_z
      assign dn2 = '0;
    end
    if (i + 1 < STACK_DEPTH) begin : g_up1
      assign up1 = ent_w[i+1];
    end else begin : g_up1_z
      assign up1 = '0;
    end
    if (i + 3 < STACK_DEPTH) begin : g_up3
      assign up3 = ent_w[i+3];
    end else begin : g_up3_z
      assign up3 = '0;
    end
    if (i < 3) begin : g_ld
      assign ctl = '{op: cell_op, load_en: ld_en[i], load_ent: ld_ent[i]};
    end else begin : g_ld_z
      assign ctl = '{op: cell_op, load_en: 1'b0, load_ent: '0};
    end

    opp_cell #(
      .CLR_ENT((i == 0) ? BOTTOM_ENT : ent_t'('0))
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .dn1   (dn1),
      .dn2   (dn2),
      .up1   (up1),
      .up3   (up3),
      .ent   (ent_w[i])
    );
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.kind  = kind_r;
  assign out_chan.rule  = rule_r;
  assign out_chan.last  = last_r;

endmodule

FILE: verif/operator_precedence_parser_core_tb.sv
`timescale 1ns / 100ps

module operator_precedence_parser_core_tb;
  import opp_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int IDLE_PCT     = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 8;

  // Token classes past the end marker are not part of the grammar
  localparam logic [TOK_W-1:0] TOK_UNKNOWN_LO = 5'd18;
  localparam logic [TOK_W-1:0] TOK_UNKNOWN_HI = 5'd31;

  typedef struct packed {
    kind_t             kind;
    logic [RULE_W-1:0] rule;
    logic              last;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  opp_in_if  in_chan ();
  opp_out_if out_chan ();

  operator_precedence_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Precedence relation, row = topmost terminal on the stack, column = token
  string prec_rows [NUM_TERM] = '{
    ">>>>>>>>>>><><<<<>",
    "<>><<>>>>>><><<<<>",
    "<>><<>>>>>><><<<<>",
    ">>>>>>>>>>><><<<<>",
    "<>><>>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<>>>>>><><<<<>",
    "<<<<<<<<<<<<=<<<<E",
    ">>>>>>>>>>>E>EEEE>",
    ">>>>>>>>>>>E>EEEE>",
    ">>>>>>>>>>>E>EEEE>",
    ">>>>>>>>>>>E>EEEE>",
    ">>>>>>>>>>>E>EEEE>",
    "<<<<<<<<<<<<E<<<<$"
  };

  // Parser shadow state and the results it still owes
  logic [SYM_W-1:0] sym_stack [OPP_STACK_DEPTH];
  int               sym_fill;
  parse_result_t    pending_results [$];
  logic [TOK_W-1:0] burst_q [$];
  parse_result_t    want;
  bit               steady;

  int mismatch_count;
  int tokens_sent;
  int results_checked;
  int cycle_count;
  int kind_hits [5];

  function automatic void reset_symbols();
    foreach (sym_stack[i]) sym_stack[i] = '0;
    sym_stack[0] = SYM_END;
    sym_fill = 1;
  endfunction

  function automatic void push_result(input kind_t k, input logic [RULE_W-1:0] r,
                                      input logic l);
    parse_result_t res;
    res.kind = k;
    res.rule = r;
    res.last = l;
    pending_results.push_back(res);
  endfunction

  function automatic rel_t table_rel(input logic [SYM_W-1:0] row,
                                     input logic [TOK_W-1:0] col);
    byte ch;
    ch = prec_rows[row][col];
    case (ch)
      "<":     return REL_LT;
      "=":     return REL_EQ;
      ">":     return REL_GT;
      "$":     return REL_ACC;
      default: return REL_ERR;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] top_terminal();
    for (int i = sym_fill - 1; i >= 0; i--) begin
      if (sym_stack[i] <= SYM_END) return sym_stack[i];
    end
    return SYM_END;
  endfunction

  // Runs one token through the shadow parser and queues every result it causes
  function automatic void parse_token(input logic [TOK_W-1:0] tok);
    rel_t              rel;
    int                produced;
    int                start;
    int                hlen;
    int                need;
    logic [RULE_W-1:0] rule;
    produced = 0;
    if (tok > SYM_END) begin
      reset_symbols();
      push_result(KIND_SYNTAX, RULE_NONE, 1'b1);
      return;
    end
    while (1) begin
      rel = table_rel(top_terminal(), tok);
      if (rel == REL_ACC) begin
        reset_symbols();
        push_result(KIND_ACCEPT, RULE_NONE, 1'b1);
        return;
      end
      // shift, with a handle marker on "<" (slid under a nonterminal on top)
      if (rel == REL_LT || rel == REL_EQ) begin
        need = (rel == REL_LT) ? 2 : 1;
        if (sym_fill + need > OPP_STACK_DEPTH) begin
          reset_symbols();
          push_result(KIND_OVERFLOW, RULE_NONE, 1'b1);
          return;
        end
        if (rel == REL_LT) begin
          if (sym_stack[sym_fill-1] == SYM_NT) begin
            sym_stack[sym_fill-1] = SYM_MARK;
            sym_stack[sym_fill]   = SYM_NT;
          end else begin
            sym_stack[sym_fill] = SYM_MARK;
          end
          sym_fill++;
        end
        sym_stack[sym_fill] = tok;
        sym_fill++;
        push_result(KIND_SHIFT, RULE_NONE, 1'b1);
        return;
      end
      if (rel != REL_GT) begin
        reset_symbols();
        push_result(KIND_SYNTAX, RULE_NONE, 1'b1);
        return;
      end
      // reduce: handle runs from the topmost marker (or end marker) to the top
      start = sym_fill - 1;
      while (start > 0 && sym_stack[start] != SYM_MARK && sym_stack[start] != SYM_END)
        start--;
      hlen = sym_fill - start;
      rule = RULE_NONE;
      if (sym_stack[start] == SYM_MARK) begin
        if (hlen == 4 && sym_stack[start+1] == SYM_NT && sym_stack[start+3] == SYM_NT &&
            sym_stack[start+2] <= SYM_LAST_OP) begin
          rule = sym_stack[start+2] + 5'd1;
        end else if (hlen == 4 && sym_stack[start+1] == SYM_LPAR &&
                     sym_stack[start+2] == SYM_NT && sym_stack[start+3] == SYM_RPAR) begin
          rule = RULE_PAREN;
        end else if (hlen == 2 && sym_stack[start+1] >= SYM_OPND_LO &&
                     sym_stack[start+1] <= SYM_OPND_HI) begin
          rule = sym_stack[start+1];
        end
      end
      if (rule == RULE_NONE || start == 0) begin
        reset_symbols();
        push_result(KIND_SYNTAX, RULE_NONE, 1'b1);
        return;
      end
      if (produced >= MAX_RESULTS - 1) begin
        reset_symbols();
        push_result(KIND_OVERFLOW, RULE_NONE, 1'b1);
        return;
      end
      sym_stack[start] = SYM_NT;
      sym_fill = start + 1;
      push_result(KIND_REDUCE, rule, 1'b0);
      produced++;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  // Random expression appended to burst_q
  function automatic void gen_expr(input int depth);
    int pick;
    pick = $urandom_range(0, 9);
    if (depth == 0 || pick < 4) begin
      burst_q.push_back(TOK_W'($urandom_range(SYM_OPND_LO, SYM_OPND_HI)));
    end else if (pick < 6) begin
      burst_q.push_back(SYM_LPAR);
      gen_expr(depth - 1);
      burst_q.push_back(SYM_RPAR);
    end else begin
      gen_expr(depth - 1);
      burst_q.push_back(TOK_W'($urandom_range(0, SYM_LAST_OP)));
      gen_expr(depth - 1);
    end
  endfunction

  // One token request; valid stays up so the next token can follow at once
  task automatic send_token(input logic [TOK_W-1:0] tok);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.token_class <= tok;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    parse_token(tok);
    tokens_sent++;
  endtask

  task automatic send_burst();
    foreach (burst_q[i]) send_token(burst_q[i]);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Every operator and operand class, with a parenthesized group up front
  task automatic test_operator_chain();
    burst_q.delete();
    burst_q.push_back(SYM_LPAR);
    burst_q.push_back(SYM_OPND_LO);
    burst_q.push_back(TOK_W'(0));
    burst_q.push_back(TOK_W'(SYM_OPND_LO + 1));
    burst_q.push_back(SYM_RPAR);
    for (int op = 1; op <= SYM_LAST_OP; op++) begin
      burst_q.push_back(TOK_W'(op));
      burst_q.push_back(TOK_W'(SYM_OPND_LO + (op + 1) % 4));
    end
    burst_q.push_back(SYM_END);
    send_burst();
  endtask

  task automatic test_syntax_errors();
    burst_q.delete();
    burst_q.push_back(SYM_END);          // accept on an empty expression
    burst_q.push_back(TOK_UNKNOWN_LO);   // unknown token classes
    burst_q.push_back(TOK_UNKNOWN_HI);
    burst_q.push_back(SYM_RPAR);         // error relation against the end marker
    burst_q.push_back(SYM_LPAR);         // empty parens: handle matches no rule
    burst_q.push_back(SYM_RPAR);
    burst_q.push_back(SYM_END);
    burst_q.push_back(SYM_OPND_LO);      // operand facing operand
    burst_q.push_back(SYM_OPND_HI);
    send_burst();
  endtask

  // 15 open parens fill 31 slots, the operand then needs two more
  task automatic test_stack_overflow();
    burst_q.delete();
    repeat (15) burst_q.push_back(SYM_LPAR);
    burst_q.push_back(SYM_OPND_LO);
    burst_q.push_back(SYM_END);
    send_burst();
  endtask

  // Mostly well-formed expressions; some corrupted, some nested past the stack
  task automatic test_random_expressions();
    int sent;
    int expr_idx;
    int shape;
    sent     = 0;
    expr_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_q.delete();
      steady <= (expr_idx >= 15 && expr_idx < 30);
      shape = $urandom_range(0, 99);
      if (shape < 5) begin
        repeat ($urandom_range(12, 17)) burst_q.push_back(SYM_LPAR);
        gen_expr(1);
        burst_q.push_back(SYM_RPAR);
        burst_q.push_back(SYM_END);
      end else begin
        gen_expr($urandom_range(0, 4));
        if (shape < 15) begin
          burst_q[$urandom_range(0, burst_q.size() - 1)] = TOK_W'($urandom);
        end else if (shape < 20) begin
          burst_q.push_back(TOK_W'($urandom_range(TOK_UNKNOWN_LO, TOK_UNKNOWN_HI)));
        end
        burst_q.push_back(SYM_END);
      end
      send_burst();
      sent += burst_q.size();
      if (expr_idx == 10) wait_drain();
      expr_idx++;
    end
    steady <= 1'b0;
  endtask

  // Result sink with random back-pressure
  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result request with the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_checked++;
      if (out_chan.kind <= KIND_OVERFLOW) kind_hits[out_chan.kind]++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none owed: kind %0d rule %0d last %0d",
                                out_chan.kind, out_chan.rule, out_chan.last));
      end else begin
        want = pending_results.pop_front();
        if (out_chan.kind !== want.kind || out_chan.rule !== want.rule ||
            out_chan.last !== want.last) begin
          note_mismatch($sformatf("exp kind %0d rule %0d last %0d, got kind %0d rule %0d last %0d",
                                  want.kind, want.rule, want.last,
                                  out_chan.kind, out_chan.rule, out_chan.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("operator_precedence_parser_core_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.token_class = '0;
    out_chan.ready      = 1'b0;
    steady              = 1'b0;
    reset_symbols();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_operator_chain();
    wait_drain();
    test_syntax_errors();
    wait_drain();
    test_stack_overflow();
    wait_drain();
    test_random_expressions();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d owed results never came", pending_results.size()));

    $display("Run covered %0d tokens (operator chain, error cases, overflow, random exprs)",
             tokens_sent);
    $display("%0d results: %0d reduce, %0d shift, %0d accept, %0d syntax, %0d overflow",
             results_checked, kind_hits[KIND_REDUCE], kind_hits[KIND_SHIFT],
             kind_hits[KIND_ACCEPT], kind_hits[KIND_SYNTAX], kind_hits[KIND_OVERFLOW]);
    if (mismatch_count == 0) begin
      $display("operator_precedence_parser_core_tb: clean");
    end else begin
      $display("operator_precedence_parser_core_tb: errors");
    end
    $finish;
  end

endmodule
